// ----- design/sph_pkg.sv -----
// Shared types and constants for the sliding puzzle distance heuristic.
// No dependencies; imported by every module of the block.
package sph_pkg;

  // Board side limits and reset value
  localparam logic [3:0] MaxSide   = 4'd8;
  localparam logic [3:0] MinSide   = 4'd2;
  localparam logic [3:0] SideReset = 4'd4;

  // Accumulator saturation limits
  localparam logic [9:0]  ManhMax = 10'd1023;
  localparam logic [12:0] SqMax   = 13'd8191;

  // Shared compare/subtract unit width
  localparam int UnitW = 10;

  // Iteration counts: 6-bit dividend, 14-bit (padded) radicand
  localparam int DivSteps  = 6;
  localparam int SqrtSteps = 7;

  // Sequencer strobes toward the datapath
  typedef struct packed {
    logic ready;      // idle, input beat may be taken
    logic div_step;   // one restoring division step
    logic div_tile;   // division works on the tile home (else cell position)
    logic div_last;   // final step of the current division
    logic acc;        // accumulate offsets of this tile
    logic sqrt_step;  // one digit of the square root
    logic emit;       // load output register and clear board
  } ctrl_t;

endpackage

// ----- design/sph_cmpsub.sv -----
// Shared compare/subtract unit used by both the divider and the square root.
// Depends on sph_pkg for the unit width.
module sph_cmpsub
  import sph_pkg::*;
(
  input  logic [UnitW-1:0] a_i,
  input  logic [UnitW-1:0] b_i,
  output logic             ge_o,
  output logic [UnitW-1:0] diff_o
);

  // One subtract; borrow tells the compare
  logic [UnitW:0] sub;
  assign sub    = {1'b0, a_i} - {1'b0, b_i};
  assign ge_o   = ~sub[UnitW];
  assign diff_o = sub[UnitW-1:0];

endmodule

// ----- design/sph_ctrl.sv -----
// Sequencer: steps the shared unit through both divisions and the root.
// Depends on sph_pkg for ctrl_t and the step counts.
module sph_ctrl
  import sph_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  last_i,
  input  logic  out_free_i,
  output ctrl_t ctrl_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StDivP = 3'd1;
  localparam logic [2:0] StDivT = 3'd2;
  localparam logic [2:0] StAcc  = 3'd3;
  localparam logic [2:0] StSqrt = 3'd4;
  localparam logic [2:0] StDone = 3'd5;

  localparam logic [2:0] DivEnd  = 3'(DivSteps - 1);
  localparam logic [2:0] SqrtEnd = 3'(SqrtSteps - 1);

  logic [2:0] state_q, state_d;
  logic [2:0] step_q, step_d;

  // Next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StDivP;
          step_d  = '0;
        end
      end
      StDivP: begin
        step_d = step_q + 3'd1;
        if (step_q == DivEnd) begin
          state_d = StDivT;
          step_d  = '0;
        end
      end
      StDivT: begin
        step_d = step_q + 3'd1;
        if (step_q == DivEnd) begin
          state_d = StAcc;
        end
      end
      StAcc: begin
        step_d  = '0;
        state_d = last_i ? StSqrt : StIdle;
      end
      StSqrt: begin
        step_d = step_q + 3'd1;
        if (step_q == SqrtEnd) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_free_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Strobes
  always_comb begin
    ctrl_o.ready     = (state_q == StIdle);
    ctrl_o.div_step  = (state_q == StDivP) || (state_q == StDivT);
    ctrl_o.div_tile  = (state_q == StDivT);
    ctrl_o.div_last  = ctrl_o.div_step && (step_q == DivEnd);
    ctrl_o.acc       = (state_q == StAcc);
    ctrl_o.sqrt_step = (state_q == StSqrt);
    ctrl_o.emit      = (state_q == StDone) && out_free_i;
  end

endmodule

// ----- design/sliding_puzzle_distance_heuristic.sv -----
// Sliding puzzle distance heuristic: one tile per beat, Manhattan and root sums.
// A tile is taken only while idle; it runs the cell position division, the tile home
// division and accumulate; a last tile then runs the root and waits for a free output.
// Throughput is set by the one compare/subtract unit: 6 + 6 division steps per tile.
// Reset is asynchronous: side length returns to 4, board sums and position to zero.
// Depends on sph_pkg, sph_cmpsub and sph_ctrl.
module sliding_puzzle_distance_heuristic
  import sph_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  // input channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [5:0] tile_value_i,
  input  logic       last_tile_i,
  // output channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [9:0] heuristic_o,
  output logic [9:0] manhattan_sum_o,
  output logic [6:0] euclid_root_o
);

  ctrl_t ctrl;

  logic [3:0]  side_q;
  logic [5:0]  pos_q;
  logic [9:0]  manh_q;
  logic [12:0] sq_q;
  logic        full_q;
  logic [5:0]  tile_q;
  logic        last_q;
  logic [13:0] work_q;
  logic [UnitW-1:0] rem_q;
  logic [6:0]  root_q;
  logic [4:0]  rowp_q, rowt_q;
  logic [2:0]  colp_q, colt_q;
  logic        out_valid_q;
  logic [9:0]  heur_q, manh_out_q;
  logic [6:0]  root_out_q;

  logic        in_fire, out_free;
  logic [3:0]  side_eff;
  logic [6:0]  cells;

  assign in_fire    = in_valid_i && ctrl.ready;
  assign in_stall_o = ~ctrl.ready;
  assign out_free   = ~out_valid_q || ~out_stall_i;

  // Clamp side length to the supported range
  always_comb begin
    side_eff = side_q;
    if (side_q < MinSide) side_eff = MinSide;
    if (side_q > MaxSide) side_eff = MaxSide;
  end
  assign cells = 7'(side_eff) * 7'(side_eff);

  sph_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .last_i     (last_q),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  // Shared unit operands: division step or root digit
  logic [UnitW-1:0] op_a, op_b, diff;
  logic             ge;
  logic [3:0]       div_r;

  assign div_r = {rem_q[2:0], work_q[5]};

  always_comb begin
    if (ctrl.sqrt_step) begin
      op_a = {rem_q[7:0], work_q[13:12]};
      op_b = {1'b0, root_q, 2'b01};
    end else begin
      op_a = UnitW'(div_r);
      op_b = UnitW'(side_eff);
    end
  end

  sph_cmpsub u_unit (
    .a_i    (op_a),
    .b_i    (op_b),
    .ge_o   (ge),
    .diff_o (diff)
  );

  // Offsets and saturating sums of the current tile
  logic        active;
  logic [4:0]  dr;
  logic [2:0]  dc;
  logic [9:0]  dr_sq;
  logic [5:0]  dc_sq;
  logic [10:0] m_sum;
  logic [13:0] q_sum;
  logic [9:0]  manh_d;
  logic [12:0] sq_d;
  logic [6:0]  pos_inc;

  assign active  = ~full_q && ({1'b0, pos_q} < cells);
  assign dr      = (rowp_q >= rowt_q) ? (rowp_q - rowt_q) : (rowt_q - rowp_q);
  assign dc      = (colp_q >= colt_q) ? (colp_q - colt_q) : (colt_q - colp_q);
  assign dr_sq   = 10'(dr) * 10'(dr);
  assign dc_sq   = 6'(dc) * 6'(dc);
  assign m_sum   = 11'(manh_q) + 11'(dr) + 11'(dc);
  assign q_sum   = 14'(sq_q) + 14'(dr_sq) + 14'(dc_sq);
  assign pos_inc = {1'b0, pos_q} + 7'd1;

  always_comb begin
    manh_d = manh_q;
    sq_d   = sq_q;
    if (active && (tile_q != 6'd0)) begin
      manh_d = (m_sum > 11'(ManhMax)) ? ManhMax : m_sum[9:0];
      sq_d   = (q_sum > 14'(SqMax)) ? SqMax : q_sum[12:0];
    end
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= SideReset;
    end else if (cfg_we_i) begin
      side_q <= cfg_wdata_i;
    end
  end

  // Board state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      manh_q <= '0;
      sq_q   <= '0;
      full_q <= 1'b0;
    end else if (ctrl.emit) begin
      pos_q  <= '0;
      manh_q <= '0;
      sq_q   <= '0;
      full_q <= 1'b0;
    end else if (ctrl.acc) begin
      manh_q <= manh_d;
      sq_q   <= sq_d;
      if (active) begin
        pos_q <= pos_inc[5:0];
        if (pos_inc >= cells) full_q <= 1'b1;
      end
    end
  end

  // Input beat capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= 1'b0;
    end else if (in_fire) begin
      last_q <= last_tile_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      tile_q <= tile_value_i;
    end
  end

  // Iteration registers of the shared unit
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      work_q <= {8'd0, pos_q};
      rem_q  <= '0;
    end else if (ctrl.div_step) begin
      if (ctrl.div_last) begin
        if (ctrl.div_tile) begin
          rowt_q <= {work_q[3:0], ge};
          colt_q <= ge ? diff[2:0] : div_r[2:0];
        end else begin
          rowp_q <= {work_q[3:0], ge};
          colp_q <= ge ? diff[2:0] : div_r[2:0];
          work_q <= {8'd0, tile_q - 6'd1};
        end
        rem_q <= '0;
      end else begin
        work_q <= {8'd0, work_q[4:0], ge};
        rem_q  <= UnitW'(ge ? diff[2:0] : div_r[2:0]);
      end
    end else if (ctrl.acc) begin
      work_q <= {1'b0, sq_d};
      rem_q  <= '0;
      root_q <= '0;
    end else if (ctrl.sqrt_step) begin
      work_q <= {work_q[11:0], 2'b00};
      rem_q  <= ge ? diff : op_a;
      root_q <= {root_q[5:0], ge};
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_q <= 1'b1;
    end else if (~out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit) begin
      heur_q     <= (manh_q >= 10'(root_q)) ? manh_q : 10'(root_q);
      manh_out_q <= manh_q;
      root_out_q <= root_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign heuristic_o     = heur_q;
  assign manhattan_sum_o = manh_out_q;
  assign euclid_root_o   = root_out_q;

`ifndef SYNTHESIS
  // An accepted beat starts the cell position division
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (ctrl.div_step && !ctrl.div_tile))
    else $error("accepted beat did not start division");

  // Result only loads when the output register can take it
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.emit |-> (!out_valid_q || !out_stall_i))
    else $error("result overwrote a waiting beat");

  // Root is the floor square root of the squared sum
  a_root_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.emit |-> ((16'(root_q) * 16'(root_q) <= 16'(sq_q)) &&
                   ((16'(root_q) + 16'd1) * (16'(root_q) + 16'd1) > 16'(sq_q))))
    else $error("square root out of bounds");

  // Board is cleared after each result
  a_board_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.emit |=> (pos_q == 6'd0 && manh_q == 10'd0 && sq_q == 13'd0 && !full_q))
    else $error("board not cleared after result");
`endif

endmodule
